### rtl/core/ahv_pkg.sv
package ahv_pkg;

  // fixed field widths
  localparam int STEP_W     = 24;
  localparam int DEPTH_W    = 20;
  localparam int LEVEL_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // harmonic bookkeeping, sized for up to eight harmonics
  localparam int AMP_INPUTS = 7;
  localparam int AMP_SLOTS  = 8;
  localparam int HIDX_W     = 3;
  localparam int CNT_W      = 4;
  localparam int ACC_W      = 34;
  localparam int MAG_W      = ACC_W - 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAN          = 2'd1;

  // reset values and fixed-point constants
  localparam logic [STEP_W-1:0]  VIB_STEP_RESET = 24'd2283;
  localparam logic [LEVEL_W-1:0] PAN_RESET      = 16'd16384;
  localparam logic [LEVEL_W-1:0] VOL_RESET      = 16'd3277;
  localparam logic [LEVEL_W-1:0] UNITY          = 16'd32768;
  localparam logic [LEVEL_W-1:0] SMOOTH_KEEP    = 16'd26214;
  localparam logic [LEVEL_W-1:0] SMOOTH_TAKE    = 16'd6554;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COS,
    ST_DEV,
    ST_THETA,
    ST_HARM,
    ST_ABS,
    ST_SCALE1,
    ST_SCALE2,
    ST_FIN
  } ahv_state_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              cos_rd;
    logic              dev;
    logic              theta;
    logic              issue;
    logic              mul;
    logic              acc;
    logic              absval;
    logic              scale1;
    logic              scale2;
    logic              fin;
    logic [HIDX_W-1:0] harm_idx;
  } ahv_cmd_t;

  // handshake status seen by the controller
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } ahv_stat_t;

  function automatic logic [LEVEL_W-1:0] clamp_unity(input logic [LEVEL_W-1:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  // quarter-wave sine magnitude, polynomial evaluated at elaboration
  function automatic logic [14:0] sine_mag(input int u, input int tbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    x  = longint'(u) << (18 - tbits);
    x2 = (x * x) >> 16;
    t  = 307;
    t  = 5223 - ((x2 * t) >> 16);
    t  = 42334 - ((x2 * t) >> 16);
    t  = 102944 - ((x2 * t) >> 16);
    y  = (x * t) >> 16;
    y  = (y + 1) >> 1;
    if (y > 32767) begin
      y = 32767;
    end
    return 15'(y);
  endfunction

endpackage

### rtl/core/ahv_if.sv
// input word channel
interface ahv_in_if;
  import ahv_pkg::*;
  logic                valid;
  logic                ready;
  logic                block_start;
  logic [STEP_W-1:0]   phase_step;
  logic [DEPTH_W-1:0]  vibrato_depth;
  logic [LEVEL_W-1:0]  target_volume;
  logic [LEVEL_W-1:0]  amp_1;
  logic [LEVEL_W-1:0]  amp_2;
  logic [LEVEL_W-1:0]  amp_3;
  logic [LEVEL_W-1:0]  amp_4;
  logic [LEVEL_W-1:0]  amp_5;
  logic [LEVEL_W-1:0]  amp_6;
  logic [LEVEL_W-1:0]  amp_7;

  modport source (
    output valid, block_start, phase_step, vibrato_depth, target_volume,
           amp_1, amp_2, amp_3, amp_4, amp_5, amp_6, amp_7,
    input  ready
  );
  modport sink (
    input  valid, block_start, phase_step, vibrato_depth, target_volume,
           amp_1, amp_2, amp_3, amp_4, amp_5, amp_6, amp_7,
    output ready
  );
endinterface

// output word channel
interface ahv_out_if;
  import ahv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

### rtl/core/ahv_ctrl.sv
module ahv_ctrl
  import ahv_pkg::*;
#(
  parameter int NUM_HARMONICS = 7
) (
  input  logic      clk,
  input  logic      rst,
  input  ahv_stat_t stat,
  output logic      in_ready,
  output ahv_cmd_t  cmd
);

  localparam logic [CNT_W-1:0] N_H      = CNT_W'(NUM_HARMONICS);
  localparam logic [CNT_W-1:0] N_H_LAST = CNT_W'(NUM_HARMONICS + 1);

  ahv_state_t       state;
  ahv_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // state and harmonic counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // sequencing: one word at a time, harmonic loop is a 3-stage pipe
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.harm_idx = cnt[HIDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_COS;
        end
      end
      ST_COS: begin
        cmd.cos_rd = 1'b1;
        state_next = ST_DEV;
      end
      ST_DEV: begin
        cmd.dev    = 1'b1;
        state_next = ST_THETA;
      end
      ST_THETA: begin
        cmd.theta  = 1'b1;
        cnt_next   = '0;
        state_next = ST_HARM;
      end
      ST_HARM: begin
        cmd.issue = (cnt < N_H);
        cmd.mul   = (cnt != '0) && (cnt <= N_H);
        cmd.acc   = (cnt >= CNT_W'(2));
        if (cnt == N_H_LAST) begin
          state_next = ST_ABS;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_ABS: begin
        cmd.absval = 1'b1;
        state_next = ST_SCALE1;
      end
      ST_SCALE1: begin
        cmd.scale1 = 1'b1;
        state_next = ST_SCALE2;
      end
      ST_SCALE2: begin
        cmd.scale2 = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // an accepted word always starts with the cosine lookup
  a_load_then_cos: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.cos_rd)
    else $error("cosine lookup did not follow accept");

  // harmonic loop starts at the fundamental right after theta
  a_theta_then_first: assert property (@(posedge clk) disable iff (rst)
    cmd.theta |=> (cmd.issue && cmd.harm_idx == '0 && !cmd.acc))
    else $error("harmonic loop did not start at the fundamental");

  // scaling only after the magnitude of the sum is taken
  a_abs_before_scale: assert property (@(posedge clk) disable iff (rst)
    cmd.scale1 |-> $past(cmd.absval))
    else $error("scaling without magnitude step");

endmodule

### rtl/core/ahv_dp.sv
module ahv_dp
  import ahv_pkg::*;
#(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ahv_cmd_t              cmd,
  output ahv_stat_t             stat,
  ahv_in_if.sink                din,
  ahv_out_if.source             dout
);

  localparam int QSIZE = 1 << (SINE_TABLE_BITS - 2);
  localparam int UW    = SINE_TABLE_BITS - 1;
  localparam int PQW   = SINE_TABLE_BITS - 2;
  localparam int PRODW = 31;
  localparam int DEVW  = 21;
  localparam int M1W   = 34;
  localparam int M2W   = 20;

  function automatic logic signed [SAMPLE_W-1:0] saturate(input logic [M2W-1:0] m,
                                                          input logic neg);
    if (neg) begin
      if (m > M2W'(32768)) return 16'sh8000;
      return SAMPLE_W'(~m + M2W'(1));
    end
    if (m > M2W'(32767)) return 16'sh7FFF;
    return SAMPLE_W'(m);
  endfunction

  // quarter-wave sine table, entries 0 .. QSIZE
  logic [14:0] qtab [QSIZE+1];
  for (genvar g = 0; g <= QSIZE; g++) begin : g_qtab
    assign qtab[g] = sine_mag(g, SINE_TABLE_BITS);
  end

  // configuration and persistent state
  logic [STEP_W-1:0]     vib_step;
  logic [LEVEL_W-1:0]    pan;
  logic [PHASE_BITS-1:0] main_phase;
  logic [PHASE_BITS-1:0] vib_phase;
  logic [LEVEL_W-1:0]    vol;

  // per-word registers
  logic                  smooth_flag;
  logic [DEPTH_W-1:0]    depth;
  logic [LEVEL_W-1:0]    target;
  logic [LEVEL_W-1:0]    amps [AMP_SLOTS];
  logic [14:0]           sin_mag;
  logic                  sin_neg;
  logic [DEVW-1:0]       dev;
  logic [PHASE_BITS-1:0] theta;
  logic [PHASE_BITS-1:0] angle;
  logic [LEVEL_W-1:0]    amp_val;
  logic [PRODW-1:0]      prod;
  logic                  prod_neg;
  logic signed [ACC_W-1:0] acc;
  logic [MAG_W-1:0]      mag;
  logic                  neg;
  logic [M1W-1:0]        m1;
  logic [M2W-1:0]        m2l;
  logic [M2W-1:0]        m2r;
  logic                  out_valid;

  // combinational helpers
  logic [SINE_TABLE_BITS-1:0] tidx;
  logic [1:0]                 quad;
  logic [PQW-1:0]             pq;
  logic [UW-1:0]              u;
  logic [35:0]                dev_full;
  logic [PHASE_BITS-1:0]      theta_new;
  logic [31:0]                vol_full;
  logic [48:0]                m1_full;
  logic [49:0]                m2l_full;
  logic [49:0]                m2r_full;
  logic [LEVEL_W-1:0]         gain_l;

  // shared table lookup: cosine of the vibrato phase or sine of the harmonic angle
  always_comb begin
    if (cmd.cos_rd) begin
      tidx = vib_phase[PHASE_BITS-1 -: SINE_TABLE_BITS] + SINE_TABLE_BITS'(QSIZE);
    end else begin
      tidx = angle[PHASE_BITS-1 -: SINE_TABLE_BITS];
    end
    quad = tidx[SINE_TABLE_BITS-1 -: 2];
    pq   = tidx[PQW-1:0];
    u    = quad[0] ? (UW'(QSIZE) - {1'b0, pq}) : {1'b0, pq};
  end

  // arithmetic of the individual steps
  always_comb begin
    dev_full  = 36'(depth) * 36'(sin_mag) + 36'd16384;
    theta_new = sin_neg ? (main_phase - PHASE_BITS'(dev))
                        : (main_phase + PHASE_BITS'(dev));
    vol_full  = 32'(SMOOTH_KEEP) * 32'(vol) + 32'(SMOOTH_TAKE) * 32'(target) + 32'd16384;
    m1_full   = 49'(mag) * 49'(vol) + 49'd16384;
    gain_l    = UNITY - pan;
    m2l_full  = 50'(m1) * 50'(gain_l) + 50'd536870912;
    m2r_full  = 50'(m1) * 50'(pan) + 50'd536870912;
  end

  // configuration registers, out-of-range pan clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      vib_step <= VIB_STEP_RESET;
      pan      <= PAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIBRATO_STEP: vib_step <= cfg_data[STEP_W-1:0];
        REG_PAN:          pan      <= clamp_unity(cfg_data[LEVEL_W-1:0]);
        default: ;
      endcase
    end
  end

  // phases advance on accept, volume smoothing alongside the cosine lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase <= '0;
      vib_phase  <= '0;
      vol        <= VOL_RESET;
    end else begin
      if (cmd.load) begin
        main_phase <= main_phase + PHASE_BITS'(din.phase_step);
        vib_phase  <= vib_phase + PHASE_BITS'(vib_step);
      end
      if (cmd.cos_rd && smooth_flag) begin
        vol <= vol_full[30:15];
      end
    end
  end

  // word capture, amplitudes clamped to unity
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smooth_flag <= din.block_start;
      depth       <= din.vibrato_depth;
      target      <= clamp_unity(din.target_volume);
      amps[0]     <= clamp_unity(din.amp_1);
      amps[1]     <= clamp_unity(din.amp_2);
      amps[2]     <= clamp_unity(din.amp_3);
      amps[3]     <= clamp_unity(din.amp_4);
      amps[4]     <= clamp_unity(din.amp_5);
      amps[5]     <= clamp_unity(din.amp_6);
      amps[6]     <= clamp_unity(din.amp_7);
      amps[7]     <= '0;
    end
  end

  // vibrato deviation, theta, harmonic multiply-accumulate, output scaling
  always_ff @(posedge clk) begin
    if (cmd.cos_rd || cmd.issue) begin
      sin_mag <= qtab[u];
      sin_neg <= quad[1];
    end
    if (cmd.issue) begin
      amp_val <= amps[cmd.harm_idx];
      angle   <= angle + theta;
    end
    if (cmd.dev) begin
      dev <= dev_full[35:15];
    end
    if (cmd.theta) begin
      theta <= theta_new;
      angle <= theta_new;
      acc   <= '0;
    end
    if (cmd.mul) begin
      prod     <= PRODW'(amp_val * sin_mag);
      prod_neg <= sin_neg;
    end
    if (cmd.acc) begin
      acc <= prod_neg ? (acc - $signed(ACC_W'(prod))) : (acc + $signed(ACC_W'(prod)));
    end
    if (cmd.absval) begin
      neg <= acc[ACC_W-1];
      mag <= acc[ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
    end
    if (cmd.scale1) begin
      m1 <= m1_full[48:15];
    end
    if (cmd.scale2) begin
      m2l <= m2l_full[49:30];
      m2r <= m2r_full[49:30];
    end
    if (cmd.fin) begin
      dout.left_sample  <= saturate(m2l, neg);
      dout.right_sample <= saturate(m2r, neg);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign dout.valid    = out_valid;
  assign stat.in_valid = din.valid;
  assign stat.out_free = !out_valid || dout.ready;

  // the accumulator starts every word from zero
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.theta |=> (acc == '0))
    else $error("accumulator not cleared at theta");

  // a finished word is always presented
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> dout.valid)
    else $error("output word lost after finish");

endmodule

### rtl/core/additive_harmonic_vibrato_oscillator.sv
// words are taken one at a time: a new word is accepted only after the previous one
// has been finished into the output register, since the single shared table lookup and
//   multiply-accumulate visit each harmonic in turn
// the output register lets the result wait while the next word is taken
// reset: phases zero, volume 3277, vibrato_step 2283, pan 16384, output empty
module additive_harmonic_vibrato_oscillator
  import ahv_pkg::*;
#(
  parameter int NUM_HARMONICS   = 7,
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ahv_in_if.sink                din,
  ahv_out_if.source             dout
);

  ahv_cmd_t  cmd;
  ahv_stat_t stat;
  logic      in_ready;

  assign din.ready = in_ready;

  // sequencer
  ahv_ctrl #(
    .NUM_HARMONICS(NUM_HARMONICS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // datapath
  ahv_dp #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .din      (din),
    .dout     (dout)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import ahv_pkg::*;

  localparam int PH_BITS      = 24;
  localparam int LUT_BITS     = 10;
  localparam int LUT_SIZE     = 1 << LUT_BITS;
  localparam int QUARTER      = LUT_SIZE / 4;
  localparam int HARMONICS    = 7;
  localparam int SETTLE_TICKS = 24;
  localparam int LIMIT_CYCLES = 400000;

  // indexes outside the register map, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    bit                block_start;
    bit [STEP_W-1:0]   phase_step;
    bit [DEPTH_W-1:0]  depth;
    bit [LEVEL_W-1:0]  target;
    bit [LEVEL_W-1:0]  amp [HARMONICS];
  } osc_word_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_t;

  // predicts left/right samples and checks them in order
  class oscillator_scoreboard;
    int                sine_lut [LUT_SIZE];
    bit [PH_BITS-1:0]  vib_step;
    bit [LEVEL_W-1:0]  pan;
    bit [PH_BITS-1:0]  main_phase;
    bit [PH_BITS-1:0]  vib_phase;
    bit [LEVEL_W-1:0]  volume;
    stereo_t           expected_samples [$];
    int                errors;

    function new();
      longint quad, p, u, x, x2, t, y;
      // quarter-wave polynomial sine, mirrored and negated per quarter
      for (int i = 0; i < LUT_SIZE; i++) begin
        quad = (i / QUARTER) % 4;
        p    = i % QUARTER;
        u    = (quad % 2 == 1) ? QUARTER - p : p;
        x    = u << (18 - LUT_BITS);
        x2   = (x * x) >> 16;
        t    = 307;
        t    = 5223 - ((x2 * t) >> 16);
        t    = 42334 - ((x2 * t) >> 16);
        t    = 102944 - ((x2 * t) >> 16);
        y    = (x * t) >> 16;
        y    = (y + 1) >> 1;
        if (y > 32767) begin
          y = 32767;
        end
        sine_lut[i] = (quad >= 2) ? -int'(y) : int'(y);
      end
      vib_step   = VIB_STEP_RESET;
      pan        = PAN_RESET;
      main_phase = '0;
      vib_phase  = '0;
      volume     = VOL_RESET;
      errors     = 0;
    endfunction

    function longint cap_level(bit [LEVEL_W-1:0] v);
      return (v > UNITY) ? longint'(UNITY) : longint'(v);
    endfunction

    function int lut_at(bit [PH_BITS-1:0] ph);
      return sine_lut[ph >> (PH_BITS - LUT_BITS)];
    endfunction

    // two rounding steps: by volume, then by channel gain, then saturate
    function logic signed [SAMPLE_W-1:0] scale_channel(longint mag, bit neg, longint vol,
                                                       longint gain);
      longint m1, m2, r;
      m1 = (mag * vol + 16384) >>> 15;
      m2 = (m1 * gain + (longint'(1) << 29)) >>> 30;
      if (neg) begin
        r = (m2 > 32768) ? -32768 : -m2;
      end else begin
        r = (m2 > 32767) ? 32767 : m2;
      end
      return SAMPLE_W'(r);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_VIBRATO_STEP: vib_step = data[PH_BITS-1:0];
        REG_PAN:          pan = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_word(osc_word_t w);
      int               c;
      longint           cmag, dev, acc, mag, pn;
      bit [PH_BITS-1:0] theta;
      stereo_t          s;
      // volume smoothing on the first sample of a buffer
      if (w.block_start) begin
        volume = LEVEL_W'((longint'(SMOOTH_KEEP) * volume
                           + longint'(SMOOTH_TAKE) * cap_level(w.target) + 16384) >> 15);
      end
      vib_phase  = vib_phase + vib_step;
      main_phase = main_phase + w.phase_step;
      // vibrato deviation from the cosine of the vibrato phase
      c    = sine_lut[((vib_phase >> (PH_BITS - LUT_BITS)) + QUARTER) % LUT_SIZE];
      cmag = (c < 0) ? -c : c;
      dev  = (longint'(w.depth) * cmag + 16384) >> 15;
      if (c < 0) begin
        theta = main_phase - PH_BITS'(dev);
      end else begin
        theta = main_phase + PH_BITS'(dev);
      end
      // harmonic sum in Q3.30
      acc = 0;
      for (int k = 1; k <= HARMONICS; k++) begin
        acc += cap_level(w.amp[k-1]) * lut_at(theta * PH_BITS'(k));
      end
      mag     = (acc < 0) ? -acc : acc;
      pn      = cap_level(pan);
      s.left  = scale_channel(mag, acc < 0, volume, longint'(UNITY) - pn);
      s.right = scale_channel(mag, acc < 0, volume, pn);
      expected_samples.insert(expected_samples.size(), s);
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
      stereo_t s;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected word left %0d right %0d", $time, l, r);
        errors++;
        return;
      end
      s = expected_samples.pop_front();
      if (l !== s.left) begin
        $display("%0t: left_sample mismatch expected %0d actual %0d", $time, s.left, l);
        errors++;
      end
      if (r !== s.right) begin
        $display("%0t: right_sample mismatch expected %0d actual %0d", $time, s.right, r);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    no_gaps = 1'b0;
  int                    cycle_count = 0;

  oscillator_scoreboard sb = new();

  ahv_in_if  din_ch ();
  ahv_out_if dout_ch ();

  additive_harmonic_vibrato_oscillator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_ch),
    .dout      (dout_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output backpressure
  initial begin
    dout_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      dout_ch.ready <= no_gaps || ($urandom_range(99) >= 27);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // monitor both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (din_ch.valid && din_ch.ready) begin
        sb.predict_word('{din_ch.block_start, din_ch.phase_step, din_ch.vibrato_depth,
                          din_ch.target_volume,
                          '{din_ch.amp_1, din_ch.amp_2, din_ch.amp_3, din_ch.amp_4,
                            din_ch.amp_5, din_ch.amp_6, din_ch.amp_7}});
      end
      if (dout_ch.valid && dout_ch.ready) begin
        sb.check_sample(dout_ch.left_sample, dout_ch.right_sample);
      end
    end
  end

  task automatic send_word(input osc_word_t w);
    while (!no_gaps && $urandom_range(99) < 27) begin
      din_ch.valid <= 1'b0;
      @(posedge clk);
    end
    din_ch.valid         <= 1'b1;
    din_ch.block_start   <= w.block_start;
    din_ch.phase_step    <= w.phase_step;
    din_ch.vibrato_depth <= w.depth;
    din_ch.target_volume <= w.target;
    din_ch.amp_1         <= w.amp[0];
    din_ch.amp_2         <= w.amp[1];
    din_ch.amp_3         <= w.amp[2];
    din_ch.amp_4         <= w.amp[3];
    din_ch.amp_5         <= w.amp[4];
    din_ch.amp_6         <= w.amp[5];
    din_ch.amp_7         <= w.amp[6];
    do begin
      @(posedge clk);
    end while (!din_ch.ready);
  endtask

  // wait until every predicted sample has come out, then let the pipe empty
  task automatic settle();
    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [LEVEL_W-1:0] rand_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return UNITY;
      2:       return LEVEL_W'($urandom_range(65535, 32769));
      default: return LEVEL_W'($urandom_range(32768));
    endcase
  endfunction

  function automatic osc_word_t rand_word();
    osc_word_t w;
    w.block_start = ($urandom_range(99) < 35);
    case ($urandom_range(7))
      0:       w.phase_step = '0;
      1:       w.phase_step = 24'h800000;
      2:       w.phase_step = 24'hFFFFFF;
      3:       w.phase_step = STEP_W'($urandom_range(4095));
      default: w.phase_step = STEP_W'($urandom);
    endcase
    case ($urandom_range(5))
      0:       w.depth = '0;
      1:       w.depth = '1;
      default: w.depth = DEPTH_W'($urandom);
    endcase
    w.target = rand_level();
    foreach (w.amp[k]) begin
      w.amp[k] = rand_level();
    end
    return w;
  endfunction

  function automatic osc_word_t quiet_word();
    osc_word_t w;
    w.block_start = 1'b0;
    w.phase_step  = '0;
    w.depth       = '0;
    w.target      = '0;
    foreach (w.amp[k]) begin
      w.amp[k] = '0;
    end
    return w;
  endfunction

  task automatic directed_words();
    osc_word_t w;
    // silence
    send_word(quiet_word());
    // quarter turn, pure fundamental
    w = quiet_word();
    w.phase_step = 24'h400000;
    w.amp[0]     = UNITY;
    send_word(w);
    // half turn with the deepest vibrato
    w.phase_step = 24'h800000;
    w.depth      = '1;
    w.amp[1]     = UNITY;
    send_word(w);
    // largest step, out-of-range amplitude
    w = quiet_word();
    w.phase_step = '1;
    w.amp[2]     = 16'hFFFF;
    send_word(w);
    // each harmonic on its own
    for (int k = 0; k < HARMONICS; k++) begin
      w = quiet_word();
      w.phase_step = 24'h0A3D71;
      w.depth      = 20'h80000;
      w.amp[k]     = UNITY;
      send_word(w);
    end
    // pump the volume up with everything at full scale to drive the sum into saturation
    for (int n = 0; n < 12; n++) begin
      w = quiet_word();
      w.block_start = 1'b1;
      w.target      = 16'hFFFF;
      w.phase_step  = STEP_W'($urandom);
      w.depth       = DEPTH_W'($urandom);
      foreach (w.amp[k]) begin
        w.amp[k] = 16'hFFFF;
      end
      send_word(w);
    end
    // volume smoothing toward zero, then toward unity
    w.target = '0;
    send_word(w);
    w.target = UNITY;
    send_word(w);
  endtask

  task automatic random_phase(input int count, input bit steady);
    no_gaps = steady;
    repeat (count) send_word(rand_word());
    settle();
    no_gaps = 1'b0;
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    din_ch.valid         <= 1'b0;
    din_ch.block_start   <= 1'b0;
    din_ch.phase_step    <= '0;
    din_ch.vibrato_depth <= '0;
    din_ch.target_volume <= '0;
    din_ch.amp_1         <= '0;
    din_ch.amp_2         <= '0;
    din_ch.amp_3         <= '0;
    din_ch.amp_4         <= '0;
    din_ch.amp_5         <= '0;
    din_ch.amp_6         <= '0;
    din_ch.amp_7         <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values first
    directed_words();
    settle();

    // hard left, vibrato frozen, writes to unmapped indexes
    write_reg(REG_PAN, '0);
    write_reg(REG_VIBRATO_STEP, '0);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    random_phase(100, 1'b0);

    // hard right, fastest in-range vibrato
    write_reg(REG_PAN, 24'd32768);
    write_reg(REG_VIBRATO_STEP, 24'h800000);
    random_phase(100, 1'b0);

    // out-of-range pan, full-scale vibrato step, no idling on either side
    write_reg(REG_PAN, 24'h00FFFF);
    write_reg(REG_VIBRATO_STEP, 24'hFFFFFF);
    random_phase(100, 1'b1);

    // arbitrary settings
    write_reg(REG_PAN, CFG_DATA_W'($urandom_range(32768)));
    write_reg(REG_VIBRATO_STEP, CFG_DATA_W'($urandom));
    random_phase(150, 1'b0);

    // back to the reset settings
    write_reg(REG_PAN, CFG_DATA_W'(PAN_RESET));
    write_reg(REG_VIBRATO_STEP, CFG_DATA_W'(VIB_STEP_RESET));
    random_phase(175, 1'b0);

    if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
